@@ sv/fixed_point_alu_top_defines.svh @@
// assertion macros for the fixed-point alu checker
`ifndef FIXED_POINT_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_ALU_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpa check failed");

// condition that must never hold outside reset
`define FPA_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fpa check failed");

`endif

@@ sv/fpa_pkg.sv @@
// package: words, command codes and pipeline control for the fixed-point alu
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [3:0] CMD_ADD     = 4'd0;
  localparam logic [3:0] CMD_SUB     = 4'd1;
  localparam logic [3:0] CMD_MUL     = 4'd2;
  localparam logic [3:0] CMD_DIV     = 4'd3;
  localparam logic [3:0] CMD_LT      = 4'd4;
  localparam logic [3:0] CMD_LE      = 4'd5;
  localparam logic [3:0] CMD_GT      = 4'd6;
  localparam logic [3:0] CMD_GE      = 4'd7;
  localparam logic [3:0] CMD_EQ      = 4'd8;
  localparam logic [3:0] CMD_NE      = 4'd9;
  localparam logic [3:0] CMD_MIN     = 4'd10;
  localparam logic [3:0] CMD_MAX     = 4'd11;
  localparam logic [3:0] CMD_INC     = 4'd12;
  localparam logic [3:0] CMD_DEC     = 4'd13;
  localparam logic [3:0] CMD_TOINT   = 4'd14;
  localparam logic [3:0] CMD_FROMINT = 4'd15;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               flag;
  } fpa_out_t;

  typedef struct packed {
    logic        valid;
    logic        is_mul;
    logic        is_div;
    logic        neg;
    logic        flag;
    logic [31:0] val;
  } fpa_ctrl_t;
endpackage
`default_nettype wire

@@ sv/fpa_cell.sv @@
// one restoring-division cell: one quotient bit per cell, word carried alongside
`default_nettype none
module fpa_cell import fpa_pkg::*; #(
  parameter int NB = 40
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fpa_ctrl_t       ctrl_i,
  input  wire logic [NB-1:0]   dq_i,
  input  wire logic [31:0]     rem_i,
  input  wire logic [31:0]     dsr_i,
  output fpa_ctrl_t            ctrl_o,
  output logic [NB-1:0]        dq_o,
  output logic [31:0]          rem_o,
  output logic [31:0]          dsr_o
);
  fpa_ctrl_t     ctrl_r;
  logic [NB-1:0] dq_r, dq_nxt;
  logic [31:0]   rem_r, rem_nxt, dsr_r;
  logic [32:0]   trial;
  logic          qbit;

  always_comb begin
    trial   = {rem_i, dq_i[NB-1]};
    qbit    = (trial >= {1'b0, dsr_i});
    rem_nxt = qbit ? 32'(trial - {1'b0, dsr_i}) : trial[31:0];
    dq_nxt  = {dq_i[NB-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_i.valid;
    end
    ctrl_r.is_mul <= ctrl_i.is_mul;
    ctrl_r.is_div <= ctrl_i.is_div;
    ctrl_r.neg    <= ctrl_i.neg;
    ctrl_r.flag   <= ctrl_i.flag;
    ctrl_r.val    <= ctrl_i.val;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    dsr_r         <= dsr_i;
  end

  assign ctrl_o = ctrl_r;
  assign dq_o   = dq_r;
  assign rem_o  = rem_r;
  assign dsr_o  = dsr_r;
endmodule
`default_nettype wire

@@ sv/fpa_front.sv @@
// front stage: decode, simple operations, magnitudes and the multiplier
`default_nettype none
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NB        = 32 + FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept_i,
  input  wire fpa_in_t       in_word,
  output fpa_ctrl_t          ctrl_o,
  output logic [63:0]        prod_o,
  output logic [NB-1:0]      dq_o,
  output logic [31:0]        dsr_o
);
  fpa_ctrl_t     ctrl_r, ctrl_nxt;
  logic [63:0]   prod_r;
  logic [NB-1:0] dq_r;
  logic [31:0]   dsr_r, mag_a, mag_b;
  logic signed [31:0] a, b;
  logic          lt, gt;

  always_comb begin
    a     = in_word.operand_a;
    b     = in_word.operand_b;
    lt    = (a < b);
    gt    = (b < a);
    mag_a = a[31] ? 32'(-a) : 32'(a);
    mag_b = b[31] ? 32'(-b) : 32'(b);
    ctrl_nxt        = '0;
    ctrl_nxt.valid  = accept_i;
    ctrl_nxt.neg    = a[31] ^ b[31];
    case (in_word.command)
      CMD_ADD:     ctrl_nxt.val = 32'(a + b);
      CMD_SUB:     ctrl_nxt.val = 32'(a - b);
      CMD_MUL:     ctrl_nxt.is_mul = 1'b1;
      CMD_DIV: begin
        if (b == 32'sd0) ctrl_nxt.flag = 1'b1;
        else ctrl_nxt.is_div = 1'b1;
      end
      CMD_LT:      ctrl_nxt.flag = lt;
      CMD_LE:      ctrl_nxt.flag = !gt;
      CMD_GT:      ctrl_nxt.flag = gt;
      CMD_GE:      ctrl_nxt.flag = !lt;
      CMD_EQ:      ctrl_nxt.flag = (a == b);
      CMD_NE:      ctrl_nxt.flag = (a != b);
      CMD_MIN:     ctrl_nxt.val = lt ? a : b;
      CMD_MAX:     ctrl_nxt.val = gt ? a : b;
      CMD_INC:     ctrl_nxt.val = 32'(a + 32'sd1);
      CMD_DEC:     ctrl_nxt.val = 32'(a - 32'sd1);
      CMD_TOINT:   ctrl_nxt.val = 32'(a >>> FRAC_BITS);
      CMD_FROMINT: ctrl_nxt.val = 32'(a <<< FRAC_BITS);
      default:     ctrl_nxt.val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_nxt.valid;
    end
    ctrl_r.is_mul <= ctrl_nxt.is_mul;
    ctrl_r.is_div <= ctrl_nxt.is_div;
    ctrl_r.neg    <= ctrl_nxt.neg;
    ctrl_r.flag   <= ctrl_nxt.flag;
    ctrl_r.val    <= ctrl_nxt.val;
    prod_r        <= 64'(mag_a) * 64'(mag_b);
    dq_r          <= {mag_a, {FRAC_BITS{1'b0}}};
    dsr_r         <= mag_b;
  end

  assign ctrl_o = ctrl_r;
  assign prod_o = prod_r;
  assign dq_o   = dq_r;
  assign dsr_o  = dsr_r;
endmodule
`default_nettype wire

@@ sv/fixed_point_alu_top.sv @@
// fixed-point alu: a word can enter every cycle
// busy is always low; one word per cycle, sustained, with no stall
// a word passes the front stage, then the division chain of one cell per quotient bit
// (32 + FRAC_BITS cells), and then the output register
// synchronous active-low reset empties the pipeline; no word is lost once it is out
`default_nettype none
module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire fpa_in_t in_word,
  output logic         out_valid,
  output fpa_out_t     out_word
);
  localparam int NB = 32 + FRAC_BITS;

  fpa_ctrl_t     fr_ctrl;
  logic [63:0]   fr_prod, rnd_sum;
  logic [31:0]   mul_mag;
  fpa_ctrl_t     ch_ctrl [0:NB];
  logic [NB-1:0] ch_dq   [0:NB];
  logic [31:0]   ch_rem  [0:NB];
  logic [31:0]   ch_dsr  [0:NB];
  logic [31:0]   q, val_nxt;
  logic          up;
  logic          out_valid_r;
  fpa_out_t      out_word_r;

  assign busy = 1'b0;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .NB(NB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (start && !busy),
    .in_word  (in_word),
    .ctrl_o   (fr_ctrl),
    .prod_o   (fr_prod),
    .dq_o     (ch_dq[0]),
    .dsr_o    (ch_dsr[0])
  );

  // product rounding, half away from zero on the magnitude
  always_comb begin
    rnd_sum  = fr_prod + (64'd1 << (FRAC_BITS - 1));
    mul_mag  = rnd_sum[FRAC_BITS +: 32];
    ch_ctrl[0] = fr_ctrl;
    if (fr_ctrl.is_mul) begin
      ch_ctrl[0].val = fr_ctrl.neg ? 32'(-mul_mag) : mul_mag;
    end
  end
  assign ch_rem[0] = '0;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    fpa_cell #(.NB(NB)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ch_ctrl[i]),
      .dq_i   (ch_dq[i]),
      .rem_i  (ch_rem[i]),
      .dsr_i  (ch_dsr[i]),
      .ctrl_o (ch_ctrl[i+1]),
      .dq_o   (ch_dq[i+1]),
      .rem_o  (ch_rem[i+1]),
      .dsr_o  (ch_dsr[i+1])
    );
  end

  always_comb begin
    up      = ({ch_rem[NB], 1'b0} >= {1'b0, ch_dsr[NB]});
    q       = ch_dq[NB][31:0] + {31'd0, up};
    val_nxt = ch_ctrl[NB].val;
    if (ch_ctrl[NB].is_div) begin
      val_nxt = ch_ctrl[NB].neg ? 32'(-q) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ch_ctrl[NB].valid;
    end
    out_word_r.result_value <= val_nxt;
    out_word_r.flag         <= ch_ctrl[NB].flag;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule
`default_nettype wire

@@ sv/fpa_checker.sv @@
// port checker for the fixed-point alu, bound to the top level
`default_nettype none
`include "fixed_point_alu_top_defines.svh"
module fpa_checker import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire fpa_in_t  in_word,
  input wire logic     out_valid,
  input wire fpa_out_t out_word
);
  localparam int LAT = FRAC_BITS + 34;

  `FPA_ASSERT_NEVER(a_never_busy, busy)
  `FPA_ASSERT_IMPL(a_word_out, start && !busy, ##LAT out_valid)
  `FPA_ASSERT_IMPL(a_add_flag, start && !busy && in_word.command == CMD_ADD, ##LAT !out_word.flag)
  `FPA_ASSERT_IMPL(a_add_sum, start && !busy && in_word.command == CMD_ADD, ##LAT out_word.result_value == $past(in_word.operand_a + in_word.operand_b, LAT))
endmodule

bind fixed_point_alu_top fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the fixed-point alu: random and directed words checked against a predictor
`default_nettype none
module tb;
  import fpa_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 34 + FB;
  localparam int N_RANDOM = 1700;
  localparam longint CYCLE_LIMIT = 400000;

  class alu_scoreboard;
    fpa_out_t pending[$];
    int errors;
    int mismatches;

    function automatic logic [31:0] signed_round(logic sgn, logic [63:0] mag);
      logic [63:0] v;
      v = sgn ? (64'd0 - mag) : mag;
      return v[31:0];
    endfunction

    function automatic fpa_out_t predict(fpa_in_t w);
      fpa_out_t r;
      logic signed [31:0] a, b;
      logic [63:0] ma, mb, p, n, q;
      logic sg;
      a = w.operand_a;
      b = w.operand_b;
      ma = a[31] ? 64'(-{32'd0, a} & 64'h0_ffff_ffff) : {32'd0, a};
      mb = b[31] ? 64'(-{32'd0, b} & 64'h0_ffff_ffff) : {32'd0, b};
      sg = a[31] ^ b[31];
      r.result_value = '0;
      r.flag = 1'b0;
      case (w.command)
        CMD_ADD: r.result_value = a + b;
        CMD_SUB: r.result_value = a - b;
        CMD_MUL: begin
          p = ma * mb;
          r.result_value = signed_round(sg, (p + (64'd1 << (FB - 1))) >> FB);
        end
        CMD_DIV: begin
          if (b == 0) begin
            r.flag = 1'b1;
          end else begin
            n = ma << FB;
            q = (2 * n + mb) / (2 * mb);
            r.result_value = signed_round(sg, q);
          end
        end
        CMD_LT: r.flag = a < b;
        CMD_LE: r.flag = a <= b;
        CMD_GT: r.flag = a > b;
        CMD_GE: r.flag = a >= b;
        CMD_EQ: r.flag = a == b;
        CMD_NE: r.flag = a != b;
        CMD_MIN: r.result_value = (a < b) ? a : b;
        CMD_MAX: r.result_value = (b < a) ? a : b;
        CMD_INC: r.result_value = a + 1;
        CMD_DEC: r.result_value = a - 1;
        CMD_TOINT: r.result_value = a >>> FB;
        default: r.result_value = a << FB;
      endcase
      return r;
    endfunction

    function void note_word(fpa_in_t w);
      pending.push_back(predict(w));
    endfunction

    function void check_result(fpa_out_t got);
      fpa_out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.result_value !== exp_r.result_value || got.flag !== exp_r.flag) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: expected value %h flag %b, got value %h flag %b",
                   exp_r.result_value, exp_r.flag, got.result_value, got.flag);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  fpa_in_t in_word;
  logic out_valid;
  fpa_out_t out_word;
  longint cycles;
  alu_scoreboard results;

  fixed_point_alu_top #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    results = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) results.check_result(out_word);
    if (rst_n && start && !busy) results.note_word(in_word);
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'($urandom_range(0, 4096)) << FB;
      4: return -(32'($urandom_range(0, 4096)) << FB);
      5: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom();
    endcase
  endfunction

  // hold the word until the handshake completes
  task automatic send_word(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    in_word <= '{command: cmd, operand_a: a, operand_b: b};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_burst(bit allow);
    int n;
    if (allow && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results.pending.size() != 0) @(posedge clk);
  endtask

  logic [31:0] edge_vals[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                                32'h7fff_ffff, 32'h100};

  initial begin
    int i;
    logic [3:0] c;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every command, extreme operands, zero divisor, ties
    for (i = 0; i < 16; i++) send_word(4'(i), edge_vals[i % 6], edge_vals[(i + 3) % 6]);
    send_word(CMD_DIV, 32'h7fff_ffff, 32'h0);
    send_word(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_MUL, 32'h0000_0080, 32'h0000_0001);
    send_word(CMD_MUL, 32'hffff_ff80, 32'h0000_0001);
    send_word(CMD_MIN, 32'h5, 32'h5);
    send_word(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_TOINT, 32'hffff_ff01, 32'h0);
    send_word(CMD_DIV, 32'h1, 32'h200);
    drain();
    for (i = 0; i < N_RANDOM; i++) begin
      c = 4'($urandom_range(0, 15));
      if (i == N_RANDOM / 2) drain();
      send_word(c, pick_operand(),
                (c == CMD_DIV && $urandom_range(0, 15) == 0) ? 32'h0 : pick_operand());
      idle_burst(i < N_RANDOM - 200);
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (results.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
